FILE: rtl/core/pgs_rle_run_decoder_defines.svh
// Assertion macros for the run-length decoder checkers.
`ifndef PGS_RLE_RUN_DECODER_DEFINES_SVH
`define PGS_RLE_RUN_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PGS_RLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PGS_RLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pgs_rle_pkg.sv
// Shared types and constants of the run-length decoder.
package pgs_rle_pkg;

   localparam int COORD_BITS     = 12;
   localparam int BYTE_BITS      = 8;
   localparam int RUN_COUNT_BITS = 14;
   localparam int SUM_BITS       =
      ((COORD_BITS > RUN_COUNT_BITS) ? COORD_BITS : RUN_COUNT_BITS) + 1;

   // Two-entry queues between and after the stages.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam logic [BYTE_BITS-1:0] TRANSPARENT_INDEX = 8'hFF;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_HEIGHT = 1'b1;

   localparam logic [COORD_BITS-1:0] WINDOW_WIDTH_RESET  = 12'd1920;
   localparam logic [COORD_BITS-1:0] WINDOW_HEIGHT_RESET = 12'd1080;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 object_start;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] run_x;
      logic [COORD_BITS-1:0] run_y;
      logic [COORD_BITS-1:0] run_length;
      logic [BYTE_BITS-1:0]  color_index;
   } rsp_type;

   // One parsed byte: clear flag, lead-byte height check, finished code.
   typedef struct packed {
      logic                      object_start;
      logic                      lead_check;
      logic                      code_done;
      logic [RUN_COUNT_BITS-1:0] count;
      logic [BYTE_BITS-1:0]      color_index;
   } cmd_type;

endpackage

FILE: rtl/core/pgs_rle_parser.sv
// Front stage: parses coded bytes into run commands.
module pgs_rle_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  pgs_rle_pkg::req_type req_data,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output pgs_rle_pkg::cmd_type cmd_data
);

   localparam logic [1:0] PH_LEAD      = 2'd0;
   localparam logic [1:0] PH_SWITCH    = 2'd1;
   localparam logic [1:0] PH_COUNT_LOW = 2'd2;
   localparam logic [1:0] PH_COLOR     = 2'd3;

   logic [1:0]                             phase_ff, phase_in, phase_cur;
   logic                                   explicit_ff, explicit_in, explicit_cur;
   logic [pgs_rle_pkg::RUN_COUNT_BITS-1:0] count_ff, count_in, count_cur;
   logic [pgs_rle_pkg::BYTE_BITS-1:0]      b;
   logic                                   accept;

   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;
   assign b        = req_data.data_byte;

   // Start of object clears the parser before this byte
   assign phase_cur    = req_data.object_start ? PH_LEAD : phase_ff;
   assign explicit_cur = req_data.object_start ? 1'b0 : explicit_ff;
   assign count_cur    = req_data.object_start ? '0 : count_ff;

   // Classify the byte and advance the parse phase
   always_comb begin
      phase_in              = phase_cur;
      explicit_in           = explicit_cur;
      count_in              = count_cur;
      cmd_data.object_start = req_data.object_start;
      cmd_data.lead_check   = 1'b0;
      cmd_data.code_done    = 1'b0;
      cmd_data.count        = '0;
      cmd_data.color_index  = '0;
      unique case (phase_cur)
         PH_LEAD: begin
            cmd_data.lead_check = 1'b1;
            if (b != '0) begin
               cmd_data.code_done   = 1'b1;
               cmd_data.count       = pgs_rle_pkg::RUN_COUNT_BITS'(1);
               cmd_data.color_index = b;
            end else begin
               phase_in = PH_SWITCH;
            end
         end
         PH_SWITCH: begin
            explicit_in = b[7];
            count_in    = pgs_rle_pkg::RUN_COUNT_BITS'(b[5:0]);
            if (b[6]) begin
               phase_in = PH_COUNT_LOW;
            end else if (b[7]) begin
               phase_in = PH_COLOR;
            end else begin
               phase_in           = PH_LEAD;
               cmd_data.code_done = 1'b1;
               cmd_data.count     = pgs_rle_pkg::RUN_COUNT_BITS'(b[5:0]);
            end
         end
         PH_COUNT_LOW: begin
            count_in = {count_cur[5:0], b};
            if (explicit_cur) begin
               phase_in = PH_COLOR;
            end else begin
               phase_in           = PH_LEAD;
               cmd_data.code_done = 1'b1;
               cmd_data.count     = {count_cur[5:0], b};
            end
         end
         PH_COLOR: begin
            phase_in             = PH_LEAD;
            cmd_data.code_done   = 1'b1;
            cmd_data.count       = count_cur;
            cmd_data.color_index = b;
         end
         default: begin
            phase_in = PH_LEAD;
         end
      endcase
   end

   // Hold parser state between accepted bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEAD;
         explicit_ff <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         explicit_ff <= explicit_in;
         count_ff    <= count_in;
      end
   end

endmodule

FILE: rtl/core/pgs_rle_cmd_queue.sv
// Two-entry command queue between parser and placer.
module pgs_rle_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pgs_rle_pkg::cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output pgs_rle_pkg::cmd_type pop_data,
   output logic                 empty
);

   pgs_rle_pkg::cmd_type                   entry_ff [pgs_rle_pkg::QUEUE_DEPTH];
   logic [pgs_rle_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pgs_rle_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                                   do_push, do_pop;

   assign full     = (count_ff == pgs_rle_pkg::QUEUE_CNT_BITS'(pgs_rle_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Track the fill level
   always_comb begin
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Store commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/pgs_rle_placer.sv
// Back stage: places runs in the window and queues visible results.
module pgs_rle_placer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pgs_rle_pkg::COORD_BITS-1:0]  window_width,
   input  logic [pgs_rle_pkg::COORD_BITS-1:0]  window_height,
   input  logic                                cmd_empty,
   input  pgs_rle_pkg::cmd_type                cmd_data,
   output logic                                cmd_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output pgs_rle_pkg::rsp_type                rsp_data
);

   localparam int CW = pgs_rle_pkg::COORD_BITS;
   localparam int SW = pgs_rle_pkg::SUM_BITS;

   logic [CW-1:0] column_ff, column_in, column_cur;
   logic [CW-1:0] row_ff, row_in, row_cur, row_next;
   logic          full_ff, full_in, full_cur;
   logic          proceed, emit;

   logic [SW-1:0] run_end;
   logic          over, clip, next_line;
   logic [CW-1:0] run_len, room;

   pgs_rle_pkg::rsp_type                   out_ff [pgs_rle_pkg::QUEUE_DEPTH];
   pgs_rle_pkg::rsp_type                   out_item;
   logic [pgs_rle_pkg::QUEUE_PTR_BITS-1:0] out_wr_ptr_ff, out_rd_ptr_ff;
   logic [pgs_rle_pkg::QUEUE_CNT_BITS-1:0] out_count_ff, out_count_in;
   logic                                   out_full, out_push, out_pop;

   assign out_full  = (out_count_ff == pgs_rle_pkg::QUEUE_CNT_BITS'(pgs_rle_pkg::QUEUE_DEPTH));
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_ff[out_rd_ptr_ff];
   assign proceed   = !cmd_empty && !out_full;
   assign cmd_pop   = proceed;
   assign out_push  = proceed && emit;
   assign out_pop   = rsp_pop && !rsp_empty;

   // Start of object clears position and the full flag
   assign column_cur = cmd_data.object_start ? '0 : column_ff;
   assign row_cur    = cmd_data.object_start ? '0 : row_ff;
   assign full_cur   = cmd_data.object_start ? 1'b0 : full_ff;

   // Clip the run to the line end
   assign run_end   = SW'(column_cur) + SW'(cmd_data.count);
   assign over      = (column_cur >= window_width);
   assign clip      = (run_end > SW'(window_width));
   assign room      = window_width - column_cur;
   assign run_len   = over ? '0 : (clip ? room : cmd_data.count[CW-1:0]);
   assign next_line = (cmd_data.count == '0) || over || clip;
   assign row_next  = row_cur + 1'b1;

   // Update position for one command
   always_comb begin
      column_in = column_cur;
      row_in    = row_cur;
      full_in   = full_cur;
      emit      = 1'b0;
      priority if (full_cur) begin
         full_in = 1'b1;
      end else if (cmd_data.lead_check && (row_cur >= window_height)) begin
         full_in = 1'b1;
      end else if (cmd_data.code_done) begin
         emit = (run_len != '0) && (cmd_data.color_index != pgs_rle_pkg::TRANSPARENT_INDEX);
         if (next_line) begin
            row_in    = row_next;
            column_in = '0;
            full_in   = (row_next >= window_height);
         end else begin
            column_in = column_cur + run_len;
            full_in   = (row_cur >= window_height);
         end
      end else begin
         full_in = 1'b0;
      end
   end

   always_comb begin
      out_item.run_x       = column_cur;
      out_item.run_y       = row_cur;
      out_item.run_length  = run_len;
      out_item.color_index = cmd_data.color_index;
   end

   // Hold position state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         full_ff   <= 1'b0;
      end else if (proceed) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         full_ff   <= full_in;
      end
   end

   // Track the result queue fill level
   always_comb begin
      unique case ({out_push, out_pop})
         2'b10:   out_count_in = out_count_ff + 1'b1;
         2'b01:   out_count_in = out_count_ff - 1'b1;
         default: out_count_in = out_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         if (out_push) out_wr_ptr_ff <= out_wr_ptr_ff + 1'b1;
         if (out_pop)  out_rd_ptr_ff <= out_rd_ptr_ff + 1'b1;
         out_count_ff <= out_count_in;
      end
   end

   // Store results
   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ptr_ff] <= out_item;
      end
   end

endmodule

FILE: rtl/core/pgs_rle_run_decoder.sv
// Top level of the subtitle run-length decoder.
// Usage:
//   Request side: drive req_data (data_byte, object_start) and raise req_push;
//   a byte is taken at a rising edge with req_push high and req_full low.
//   Set object_start on the first byte of each object to clear the position.
//   Result side: while rsp_empty is low, rsp_data holds the oldest visible run
//   (x, y, length, palette index); raise rsp_pop to take it.
//   Configuration: csr_wr_en with csr_index 0 writes window_width, 1 writes
//   window_height; write only while no request is outstanding.
// Timing: one byte per cycle sustained while req_full stays low. A run shows
//   on rsp_data after its last byte is taken: the command queue registers
//   the parsed byte and the placer then writes the result queue. The rate is
//   set by the placer: it clips and places one command a cycle unless stalled.
// Stalls: when rsp_pop stays low the two-entry result queue fills, the placer
//   stops, the two-entry command queue fills and req_full rises.
// Reset: synchronous, active high; both queues empty, position at 0,0,
//   window 1920 by 1080.
module pgs_rle_run_decoder (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   input  pgs_rle_pkg::req_type                    req_data,
   output logic                                    req_full,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output pgs_rle_pkg::rsp_type                    rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [pgs_rle_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pgs_rle_pkg::COORD_BITS-1:0]      csr_wr_data
);

   logic [pgs_rle_pkg::COORD_BITS-1:0] width_ff, height_ff;
   logic                               cmd_push, cmd_full, cmd_pop, cmd_empty;
   pgs_rle_pkg::cmd_type               cmd_in, cmd_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pgs_rle_pkg::WINDOW_WIDTH_RESET;
         height_ff <= pgs_rle_pkg::WINDOW_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pgs_rle_pkg::CSR_WINDOW_WIDTH:  width_ff  <= csr_wr_data;
            pgs_rle_pkg::CSR_WINDOW_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_full = cmd_full;

   pgs_rle_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   pgs_rle_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   pgs_rle_placer u_placer (
      .clock         (clock),
      .reset         (reset),
      .window_width  (width_ff),
      .window_height (height_ff),
      .cmd_empty     (cmd_empty),
      .cmd_data      (cmd_out),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data)
   );

endmodule

FILE: rtl/core/pgs_rle_checker.sv
// Port-level checks of the run-length decoder and their binding.
`include "pgs_rle_run_decoder_defines.svh"

module pgs_rle_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_full,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  pgs_rle_pkg::rsp_type rsp_data
);

   `PGS_RLE_ASSERT_NOW(a_no_transparent, !rsp_empty,
      rsp_data.color_index != pgs_rle_pkg::TRANSPARENT_INDEX,
      "transparent run reached the result port")

   `PGS_RLE_ASSERT_NOW(a_nonzero_length, !rsp_empty, rsp_data.run_length != '0,
      "empty run reached the result port")

   `PGS_RLE_ASSERT_NEXT(a_result_held, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_data), "waiting result changed or vanished")

   `PGS_RLE_ASSERT_NOW(a_empty_after_reset, $past(reset), rsp_empty && !req_full,
      "queues not empty after reset")

endmodule

bind pgs_rle_run_decoder pgs_rle_checker u_checker (.*);
